// ===== rtl/ear_pkg.sv =====
// Package for the encoder angle rate estimator: widths, register indexes,
// sequencer states and the per-link state record. No dependencies.
package ear_pkg;

   localparam int MAX_LINKS  = 4;
   localparam int MAX_DELAY  = 16;
   localparam int LINK_W     = $clog2(MAX_LINKS);
   localparam int DLY_IDX_W  = $clog2(MAX_DELAY);
   localparam int DLY_AW     = LINK_W + DLY_IDX_W;
   localparam int DLY_DEPTH  = MAX_LINKS * MAX_DELAY;
   localparam int PUSH_W     = DLY_IDX_W + 1;

   localparam int ANGLE_W    = 32;
   localparam int OMEGA_W    = 48;
   localparam int RES_W      = 5;
   localparam int LAT_W      = 4;
   localparam int RATE_W     = 16;
   localparam int ALPHA_W    = 17;
   localparam int CSR_AW     = 2;
   localparam int CSR_DW     = 17;

   localparam logic [CSR_AW-1:0] CSR_RESOLUTION = 2'd0;
   localparam logic [CSR_AW-1:0] CSR_LATENCY    = 2'd1;
   localparam logic [CSR_AW-1:0] CSR_RATE       = 2'd2;
   localparam logic [CSR_AW-1:0] CSR_ALPHA      = 2'd3;

   localparam logic [RES_W-1:0]   RES_RESET   = 5'd12;
   localparam logic [LAT_W-1:0]   LAT_RESET   = 4'd0;
   localparam logic [RATE_W-1:0]  RATE_RESET  = 16'd1000;
   localparam logic [ALPHA_W-1:0] ALPHA_RESET = 17'd65536;
   localparam logic [ALPHA_W-1:0] ALPHA_ONE   = 17'd65536;

   localparam logic KIND_SEED    = 1'b0;
   localparam logic KIND_MEASURE = 1'b1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_DELAY,
      S_RAW,
      S_DIFF,
      S_STEP,
      S_WRITE
   } state_type;

   typedef struct packed {
      logic signed [ANGLE_W-1:0] prev;
      logic signed [OMEGA_W-1:0] filt;
      logic signed [ANGLE_W-1:0] seed;
      logic [PUSH_W-1:0]         pushes;
      logic [DLY_IDX_W-1:0]      wp;
   } link_entry_type;

endpackage

// ===== rtl/encoder_angle_rate_estimator_top.sv =====
// Encoder angle rate estimator: quantizes angles, delays them per link and
// produces a low-pass filtered backward-difference rate. Depends on ear_pkg.
// A measure word steps through READ, DELAY, RAW, DIFF, STEP and WRITE; a seed word
// through READ and WRITE. No new word is taken until WRITE ends, and WRITE waits for a
// free result register; the single sequencer owns the per-link state memory RMW per word.
// Reset restores the configuration defaults, clears the link-state valid bits and the
// control state; the delay memory is not cleared and needs no clearing pass.
module encoder_angle_rate_estimator_top
   import ear_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_kind,
   input  logic [LINK_W-1:0]         req_link,
   input  logic signed [ANGLE_W-1:0] req_angle,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [LINK_W-1:0]         rsp_link_out,
   output logic signed [ANGLE_W-1:0] rsp_theta,
   output logic signed [OMEGA_W-1:0] rsp_omega,
   input  logic                      csr_we,
   input  logic [CSR_AW-1:0]         csr_addr,
   input  logic [CSR_DW-1:0]         csr_wdata
);

   state_type state_ff, state_in;

   logic [RES_W-1:0]   res_ff;
   logic [LAT_W-1:0]   lat_ff;
   logic [RATE_W-1:0]  rate_ff;
   logic [ALPHA_W-1:0] alpha_ff;

   logic                      kind_ff;
   logic [LINK_W-1:0]         link_ff;
   logic signed [ANGLE_W-1:0] angle_ff;

   link_entry_type lnk_mem [MAX_LINKS];
   logic [MAX_LINKS-1:0] lnk_vld_ff;
   link_entry_type lnk_rdata_ff;
   logic lnk_rvld_ff;
   link_entry_type cur, lnk_wdata;

   logic signed [ANGLE_W-1:0] dly_mem [DLY_DEPTH];
   logic signed [ANGLE_W-1:0] dly_rdata_ff;
   logic [DLY_IDX_W-1:0] dly_rd_idx;

   logic signed [ANGLE_W-1:0] q_ff, q_in;
   logic signed [ANGLE_W-1:0] theta_ff, theta_in;
   logic signed [ANGLE_W:0]   diff_ff;
   logic signed [OMEGA_W-1:0] raw_ff, raw_in;
   logic [OMEGA_W:0]          dmag_ff;
   logic                      dneg_ff;
   logic [OMEGA_W+1:0]        step_ff;
   logic signed [OMEGA_W-1:0] filt_new;

   logic lnk_re, lnk_we, dly_re, dly_we, rsp_load, out_free;

   logic                      rsp_valid_ff;
   logic [LINK_W-1:0]         rsp_link_ff;
   logic signed [ANGLE_W-1:0] rsp_theta_ff;
   logic signed [OMEGA_W-1:0] rsp_omega_ff;

   // Quantizer: round half away from zero to a multiple of the step.
   logic [RES_W-1:0]   res_c;
   logic [3:0]         qsh;
   logic [ANGLE_W:0]   qstep;
   logic [ANGLE_W-1:0] qmag;
   logic [ANGLE_W:0]   qsum, qm;
   logic signed [ANGLE_W+1:0] qs;

   always_comb begin
      res_c = res_ff;
      if (res_ff < 5'd1) begin
         res_c = 5'd1;
      end else if (res_ff > 5'd16) begin
         res_c = 5'd16;
      end
      qsh   = 4'(5'd16 - res_c);
      qstep = (ANGLE_W+1)'(1) << qsh;
      qmag  = angle_ff[ANGLE_W-1] ? ANGLE_W'(-angle_ff) : angle_ff;
      qsum  = {1'b0, qmag} + (qstep >> 1);
      qm    = qsum & ~(qstep - (ANGLE_W+1)'(1));
      qs    = angle_ff[ANGLE_W-1] ? -$signed({1'b0, qm}) : $signed({1'b0, qm});
      if (qs > $signed((ANGLE_W+2)'(32'h7FFF_FFFF))) begin
         qs = qs - $signed({1'b0, qstep});
      end
      q_in = qs[ANGLE_W-1:0];
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         res_ff   <= RES_RESET;
         lat_ff   <= LAT_RESET;
         rate_ff  <= RATE_RESET;
         alpha_ff <= ALPHA_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_RESOLUTION: res_ff   <= csr_wdata[RES_W-1:0];
            CSR_LATENCY:    lat_ff   <= csr_wdata[LAT_W-1:0];
            CSR_RATE:       rate_ff  <= csr_wdata[RATE_W-1:0];
            CSR_ALPHA:      alpha_ff <= csr_wdata[ALPHA_W-1:0];
            default:        ;
         endcase
      end
   end

   // Sequencer.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (req_valid) state_in = S_READ;
         S_READ:  state_in = (kind_ff == KIND_MEASURE) ? S_DELAY : S_WRITE;
         S_DELAY: state_in = S_RAW;
         S_RAW:   state_in = S_DIFF;
         S_DIFF:  state_in = S_STEP;
         S_STEP:  state_in = S_WRITE;
         S_WRITE: if (out_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      lnk_re    = 1'b0;
      dly_re    = 1'b0;
      dly_we    = 1'b0;
      lnk_we    = 1'b0;
      rsp_load  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            lnk_re    = req_valid;
         end
         S_READ:  dly_re = (kind_ff == KIND_MEASURE);
         S_DELAY: dly_we = 1'b1;
         S_WRITE: begin
            lnk_we   = out_free;
            rsp_load = out_free;
         end
         default: ;
      endcase
   end

   // Per-link state memory; an entry never written reads as zero.
   assign cur = lnk_rvld_ff ? lnk_rdata_ff : '0;

   always_ff @(posedge clock) begin
      if (lnk_we) begin
         lnk_mem[link_ff] <= lnk_wdata;
      end
      if (lnk_re) begin
         lnk_rdata_ff <= lnk_mem[req_link];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lnk_vld_ff  <= '0;
         lnk_rvld_ff <= 1'b0;
      end else begin
         if (lnk_we) begin
            lnk_vld_ff[link_ff] <= 1'b1;
         end
         if (lnk_re) begin
            lnk_rvld_ff <= lnk_vld_ff[req_link];
         end
      end
   end

   // Delay memory: the read and write addresses differ whenever the read is used.
   assign dly_rd_idx = cur.wp - DLY_IDX_W'(lat_ff);

   always_ff @(posedge clock) begin
      if (dly_we) begin
         dly_mem[{link_ff, cur.wp}] <= q_ff;
      end
      if (dly_re) begin
         dly_rdata_ff <= dly_mem[{link_ff, dly_rd_idx}];
      end
   end

   // Datapath.
   logic signed [ANGLE_W+RATE_W+1:0] raw_prod;
   logic signed [OMEGA_W:0]          dval;
   logic [ALPHA_W-1:0]               alpha_c;
   logic [OMEGA_W+ALPHA_W:0]         step_prod;
   logic [OMEGA_W-1:0]               step_lo;

   always_comb begin
      if (cur.pushes < PUSH_W'(lat_ff)) begin
         theta_in = cur.seed;
      end else if (lat_ff == '0) begin
         theta_in = q_ff;
      end else begin
         theta_in = dly_rdata_ff;
      end

      raw_prod = diff_ff * $signed({1'b0, rate_ff});
      if (raw_prod[ANGLE_W+RATE_W+1:OMEGA_W-1] == '0 ||
          raw_prod[ANGLE_W+RATE_W+1:OMEGA_W-1] == '1) begin
         raw_in = raw_prod[OMEGA_W-1:0];
      end else if (raw_prod[ANGLE_W+RATE_W+1]) begin
         raw_in = {1'b1, {(OMEGA_W-1){1'b0}}};
      end else begin
         raw_in = {1'b0, {(OMEGA_W-1){1'b1}}};
      end

      dval = $signed({raw_ff[OMEGA_W-1], raw_ff}) - $signed({cur.filt[OMEGA_W-1], cur.filt});

      alpha_c   = (alpha_ff > ALPHA_ONE) ? ALPHA_ONE : alpha_ff;
      step_prod = dmag_ff * alpha_c + (OMEGA_W+ALPHA_W+1)'(32768);

      step_lo  = step_ff[OMEGA_W-1:0];
      filt_new = dneg_ff ? cur.filt - $signed(step_lo) : cur.filt + $signed(step_lo);
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req_valid) begin
         kind_ff  <= req_kind;
         link_ff  <= req_link;
         angle_ff <= req_angle;
      end
      if (state_ff == S_READ) begin
         q_ff <= q_in;
      end
      if (state_ff == S_DELAY) begin
         theta_ff <= theta_in;
         diff_ff  <= $signed({theta_in[ANGLE_W-1], theta_in}) -
                     $signed({cur.prev[ANGLE_W-1], cur.prev});
      end
      if (state_ff == S_RAW) begin
         raw_ff <= raw_in;
      end
      if (state_ff == S_DIFF) begin
         dneg_ff <= dval[OMEGA_W];
         dmag_ff <= dval[OMEGA_W] ? (OMEGA_W+1)'(-dval) : dval;
      end
      if (state_ff == S_STEP) begin
         step_ff <= step_prod[OMEGA_W+ALPHA_W:16];
      end
   end

   always_comb begin
      if (kind_ff == KIND_SEED) begin
         lnk_wdata.prev   = q_ff;
         lnk_wdata.filt   = '0;
         lnk_wdata.seed   = q_ff;
         lnk_wdata.pushes = '0;
         lnk_wdata.wp     = cur.wp;
      end else begin
         lnk_wdata.prev   = theta_ff;
         lnk_wdata.filt   = filt_new;
         lnk_wdata.seed   = cur.seed;
         lnk_wdata.pushes = (cur.pushes < PUSH_W'(MAX_DELAY)) ?
                            cur.pushes + PUSH_W'(1) : cur.pushes;
         lnk_wdata.wp     = cur.wp + DLY_IDX_W'(1);
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_link_ff  <= link_ff;
         rsp_theta_ff <= (kind_ff == KIND_SEED) ? q_ff : theta_ff;
         rsp_omega_ff <= (kind_ff == KIND_SEED) ? '0 : filt_new;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_link_out = rsp_link_ff;
   assign rsp_theta    = rsp_theta_ff;
   assign rsp_omega    = rsp_omega_ff;

endmodule
